### rtl/rtfd_pkg.sv
// Roundabout track feature detector: shared types and constants.
// Used by rtfd_step and the top level; depends on nothing else.
`timescale 1ns / 1ps

package rtfd_pkg;

    localparam int SENSOR_W = 12;
    localparam int HOLD_W   = 10;

    // Coil thresholds
    localparam logic [SENSOR_W-1:0] CONFIRM_MID = 12'd2000;
    localparam logic [SENSOR_W:0]   CONFIRM_SUM = 13'd3500;
    localparam logic [SENSOR_W-1:0] ENTER_MID   = 12'd2400;
    localparam logic [SENSOR_W-1:0] EXIT_MID    = 12'd1500;
    localparam logic [SENSOR_W-1:0] EXIT_LOW    = 12'd300;
    localparam logic [SENSOR_W-1:0] EXIT_EDGE   = 12'd1000;

    localparam logic [HOLD_W-1:0] HOLD_DELAY_RESET = 10'd100;

    // One input sample set
    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_mid;
        logic [SENSOR_W-1:0] sensor_3;
        logic [SENSOR_W-1:0] sensor_2;
        logic [SENSOR_W-1:0] sensor_1;
        logic [SENSOR_W-1:0] sensor_0;
        logic                on_straight;
    } item_t;

    // One result, suspect_left in bit 0
    typedef struct packed {
        logic curve_seen;
        logic ring_done;
        logic right_lamp;
        logic left_lamp;
        logic inside_res;
        logic turned_right;
        logic turned_left;
        logic entering;
        logic found_right;
        logic found_left;
        logic suspect_right;
        logic suspect_left;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Detector state carried from tick to tick
    typedef struct packed {
        logic [HOLD_W-1:0] right_hold;
        logic [HOLD_W-1:0] left_hold;
        logic              suspect_left;
        logic              suspect_right;
        logic              found_left;
        logic              found_right;
        logic              entering;
        logic              turned_left;
        logic              turned_right;
        logic              in_ring;
        logic              left_lamp;
        logic              right_lamp;
    } state_t;

    localparam state_t STATE_RESET = '{
        right_hold:    '0,
        left_hold:     '0,
        suspect_left:  1'b0,
        suspect_right: 1'b0,
        found_left:    1'b0,
        found_right:   1'b0,
        entering:      1'b0,
        turned_left:   1'b0,
        turned_right:  1'b0,
        in_ring:       1'b0,
        left_lamp:     1'b1,
        right_lamp:    1'b1
    };

endpackage

### rtl/rtfd_step.sv
// Roundabout detector tick update: next state and result from one sample set.
// Purely combinational; uses rtfd_pkg types and thresholds.
`timescale 1ns / 1ps

module rtfd_step #(
    parameter int HOLD_LIMIT = 1000
) (
    input  rtfd_pkg::state_t                 state_cur,
    input  rtfd_pkg::item_t                  item,
    input  logic [rtfd_pkg::HOLD_W-1:0]      hold_delay,
    output rtfd_pkg::state_t                 state_nxt,
    output rtfd_pkg::result_t                result
);

    localparam logic [rtfd_pkg::HOLD_W:0] LIMIT_EXT = (rtfd_pkg::HOLD_W+1)'(HOLD_LIMIT);

    logic [rtfd_pkg::SENSOR_W-1:0] s0, s1, s2, s3, sm;
    logic [rtfd_pkg::SENSOR_W:0]   h_sum;
    logic [rtfd_pkg::HOLD_W:0]     r_inc, l_inc;
    logic [rtfd_pkg::HOLD_W-1:0]   r_sat, l_sat;
    logic                          right_pat, left_pat, confirm;
    logic                          exit_left, exit_right, done;
    rtfd_pkg::state_t              st;

    assign s0 = item.sensor_0;
    assign s1 = item.sensor_1;
    assign s2 = item.sensor_2;
    assign s3 = item.sensor_3;
    assign sm = item.sensor_mid;

    // Imbalance patterns and saturating hold increments
    assign right_pat = (s0 > s1) && (s3 > s2);
    assign left_pat  = (s1 > s0) && (s2 > s3);
    assign r_inc = {1'b0, state_cur.right_hold} + 1'b1;
    assign l_inc = {1'b0, state_cur.left_hold} + 1'b1;
    assign r_sat = (r_inc >= LIMIT_EXT) ? LIMIT_EXT[rtfd_pkg::HOLD_W-1:0]
                                        : r_inc[rtfd_pkg::HOLD_W-1:0];
    assign l_sat = (l_inc >= LIMIT_EXT) ? LIMIT_EXT[rtfd_pkg::HOLD_W-1:0]
                                        : l_inc[rtfd_pkg::HOLD_W-1:0];

    assign h_sum   = {1'b0, s0} + {1'b0, s1};
    assign confirm = (sm > rtfd_pkg::CONFIRM_MID) && (h_sum > rtfd_pkg::CONFIRM_SUM);

    always_comb begin
        st         = state_cur;
        exit_left  = 1'b0;
        exit_right = 1'b0;
        done       = 1'b0;

        // Hold counters and suspicion
        if (item.on_straight) begin
            st.right_hold = right_pat ? r_sat : '0;
            st.left_hold  = left_pat  ? l_sat : '0;
            if (!state_cur.found_right && !state_cur.found_left) begin
                if (st.right_hold > hold_delay) begin
                    st.suspect_right = 1'b1;
                    st.suspect_left  = 1'b0;
                end
                if (st.left_hold > hold_delay) begin
                    st.suspect_left  = 1'b1;
                    st.suspect_right = 1'b0;
                end
            end
        end else begin
            st.right_hold    = '0;
            st.left_hold     = '0;
            st.suspect_left  = 1'b0;
            st.suspect_right = 1'b0;
        end

        // Confirmation lights the lamp of that side
        if (!state_cur.found_left && !state_cur.found_right && confirm) begin
            if (st.suspect_left) begin
                st.found_left   = 1'b1;
                st.left_lamp    = 1'b0;
                st.suspect_left = 1'b0;
            end
            if (st.suspect_right) begin
                st.found_right   = 1'b1;
                st.right_lamp    = 1'b0;
                st.suspect_right = 1'b0;
            end
        end

        // Entry
        if ((st.found_left || st.found_right) && (sm < rtfd_pkg::ENTER_MID)) begin
            st.entering = 1'b1;
        end

        // Turn-in, only once
        if (st.entering && !st.turned_left && !st.turned_right) begin
            if (st.found_left && (s1 > s0) && (s3 > s2)) begin
                st.turned_left = 1'b1;
            end
            if (st.found_right && (s0 > s1) && (s2 > s3)) begin
                st.turned_right = 1'b1;
            end
        end

        // Exit; a left completion takes priority and suppresses the right test
        if (sm < rtfd_pkg::EXIT_MID) begin
            exit_left = st.turned_left &&
                        ((s2 < rtfd_pkg::EXIT_LOW) ||
                         ((s2 > rtfd_pkg::EXIT_EDGE) && (s3 < rtfd_pkg::EXIT_EDGE)));
            exit_right = !exit_left && st.turned_right &&
                         ((s3 < rtfd_pkg::EXIT_LOW) ||
                          ((s3 > rtfd_pkg::EXIT_EDGE) && (s2 < rtfd_pkg::EXIT_EDGE)));
            done = exit_left || exit_right;
        end

        if (done) begin
            st         = rtfd_pkg::STATE_RESET;
            st.in_ring = 1'b1;
        end
    end

    assign state_nxt = st;

    // Result fields are the updated state plus ring_done and curve_seen
    assign result = '{
        curve_seen:    !item.on_straight,
        ring_done:     done,
        right_lamp:    st.right_lamp,
        left_lamp:     st.left_lamp,
        inside_res:    st.in_ring,
        turned_right:  st.turned_right,
        turned_left:   st.turned_left,
        entering:      st.entering,
        found_right:   st.found_right,
        found_left:    st.found_left,
        suspect_right: st.suspect_right,
        suspect_left:  st.suspect_left
    };

endmodule

### rtl/roundabout_track_feature_detector_unit.sv
// Roundabout track feature detector, top level: input register, tick update,
// result register and hold_delay register. Depends on rtfd_pkg and rtfd_step.
`timescale 1ns / 1ps
//
//  channel  | ports                             | one transfer carries
//  ---------+-----------------------------------+------------------------------
//  input    | s_tvalid, s_tready, s_tdata[63:0] | on_straight + five coil samples
//  result   | m_tvalid, m_tready, m_tdata[15:0] | twelve status bits
//  config   | cfg_valid, cfg_ready, cfg_data    | hold_delay (always ready)
//
// One sample set per cycle while the result is not stalled: the tick update
// sits between the input register and the result register, and an item goes
// through both on its way to result valid. Reset (aresetn low, synchronous)
// empties both registers, clears the detector state, turns both lamps off and
// sets hold_delay to 100. A stalled result register holds its item; the input
// register still takes one more transfer, then input ready follows m_tready.

module roundabout_track_feature_detector_unit #(
    parameter int HOLD_LIMIT = 1000
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rtfd_pkg::HOLD_W-1:0] cfg_data,       // hold_delay
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] on_straight, [12:1] sensor_0, [24:13] sensor_1, [36:25] sensor_2,
    // [48:37] sensor_3, [60:49] sensor_mid, [63:61] zero
    input  logic [63:0]                 s_tdata,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] suspect_left, [1] suspect_right, [2] found_left, [3] found_right,
    // [4] entering, [5] turned_left, [6] turned_right, [7] inside_res,
    // [8] left_lamp, [9] right_lamp, [10] ring_done, [11] curve_seen,
    // [15:12] zero
    output logic [15:0]                 m_tdata
);

    localparam int ITEM_W = $bits(rtfd_pkg::item_t);

    logic                        in_valid_reg;
    rtfd_pkg::item_t             in_item_reg;
    logic                        out_valid_reg;
    rtfd_pkg::result_t           out_reg;
    rtfd_pkg::state_t            state_reg;
    rtfd_pkg::state_t            state_next;
    rtfd_pkg::result_t           result_next;
    logic [rtfd_pkg::HOLD_W-1:0] hold_delay_reg;
    logic                        fire;

    // An item moves through the update when the result register is empty or being read
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= rtfd_pkg::item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    // Tick update
    rtfd_step #(
        .HOLD_LIMIT (HOLD_LIMIT)
    ) u_step (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .hold_delay (hold_delay_reg),
        .state_nxt  (state_next),
        .result     (result_next)
    );

    // Detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtfd_pkg::STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result_next;
        end
    end

    // hold_delay register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_delay_reg <= rtfd_pkg::HOLD_DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            hold_delay_reg <= cfg_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(16 - rtfd_pkg::RESULT_W)'(0), out_reg};

endmodule

### rtl/rtfd_checker.sv
// Port-level checks for the roundabout track feature detector, bound to the
// top level. Depends on nothing but the top level's ports.
`timescale 1ns / 1ps

module rtfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Completion leaves only the inside flag set and both lamps off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |->
            m_tdata[7] && m_tdata[8] && m_tdata[9] && (m_tdata[6:0] == 7'd0))
        else $error("completion left flags set");

    // Off a straight no roundabout is suspected
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> !m_tdata[0] && !m_tdata[1])
        else $error("suspect flag on a curve");

    // Each lamp is lit exactly while its side is confirmed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == !m_tdata[2]) && (m_tdata[9] == !m_tdata[3]))
        else $error("lamp disagrees with found flag");

endmodule

bind roundabout_track_feature_detector_unit rtfd_checker u_rtfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
